// ===== rtl/core/swla_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Snake walk animator package
// Shared sizes, codes, record types and the heading choice rule.
// ---------------------------------------------------------------------------
package swla_pkg;

  localparam int SNAKE_LEN = 5;
  localparam int GRID_COLS = 16;
  localparam int GRID_ROWS = 16;

  localparam int COL_W   = 4;
  localparam int ROW_W   = 4;
  localparam int IDX_W   = $clog2(SNAKE_LEN) > 0 ? $clog2(SNAKE_LEN) : 1;
  localparam int HUE_W   = 15;
  localparam int CLR_W   = 16;
  localparam int CNT_W   = 8;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam int PDATA_W   = 32;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SNAKE_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  typedef enum logic [1:0] {
    HEAD_UP    = 2'd0,
    HEAD_RIGHT = 2'd1,
    HEAD_DOWN  = 2'd2,
    HEAD_LEFT  = 2'd3
  } heading_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MOVE_INTERVAL     = 3'd0,
    REG_MOVES_BEFORE_TURN = 3'd1,
    REG_HUE_STEP          = 3'd2,
    REG_VALUE_STEP        = 3'd3,
    REG_MAX_VALUE         = 3'd4,
    REG_START_HUE         = 3'd5,
    REG_START_SAT         = 3'd6,
    REG_START_VALUE       = 3'd7
  } cfg_addr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_TURN,
    S_STEP
  } ctrl_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] move_interval;
    logic [CNT_W-1:0] moves_before_turn;
    logic [HUE_W-1:0] hue_step;
    logic [CLR_W-1:0] value_step;
    logic [CLR_W-1:0] max_value;
    logic [HUE_W-1:0] start_hue;
    logic [CLR_W-1:0] start_sat;
    logic [CLR_W-1:0] start_value;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] pixel_col;
    logic [ROW_W-1:0] pixel_row;
    logic [HUE_W-1:0] pixel_hue;
    logic [CLR_W-1:0] pixel_sat;
    logic [CLR_W-1:0] pixel_value;
    logic             frame_last;
  } pixel_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic emit;
    logic turn;
    logic step;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic move_due;
    logic slot_free;
    logic last_seg;
    logic wall;
  } dp_sts_t;

  function automatic heading_t pick_heading(heading_t dir, logic [COL_W-1:0] c,
                                            logic [ROW_W-1:0] r, logic b);
    heading_t h;
    logic     c0, cl, r0, rl;
    c0 = (c == '0);
    cl = (c == COL_LAST);
    r0 = (r == '0);
    rl = (r == ROW_LAST);
    case (dir)
      HEAD_UP: begin
        if (c0)      h = r0 ? HEAD_RIGHT : (b ? HEAD_RIGHT : HEAD_UP);
        else if (cl) h = r0 ? HEAD_LEFT : (b ? HEAD_LEFT : HEAD_UP);
        else         h = b ? HEAD_LEFT : HEAD_RIGHT;
      end
      HEAD_RIGHT: begin
        if (r0)      h = cl ? HEAD_DOWN : (b ? HEAD_DOWN : HEAD_RIGHT);
        else if (rl) h = cl ? HEAD_UP : (b ? HEAD_UP : HEAD_RIGHT);
        else         h = b ? HEAD_UP : HEAD_DOWN;
      end
      HEAD_DOWN: begin
        if (c0)      h = rl ? HEAD_RIGHT : (b ? HEAD_RIGHT : HEAD_DOWN);
        else if (cl) h = rl ? HEAD_LEFT : (b ? HEAD_LEFT : HEAD_DOWN);
        else         h = b ? HEAD_RIGHT : HEAD_LEFT;
      end
      default: begin
        if (r0)      h = c0 ? HEAD_DOWN : (b ? HEAD_DOWN : HEAD_LEFT);
        else if (rl) h = c0 ? HEAD_UP : (b ? HEAD_UP : HEAD_LEFT);
        else         h = b ? HEAD_DOWN : HEAD_UP;
      end
    endcase
    return h;
  endfunction

endpackage

// ===== rtl/core/swla_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Snake walk animator channels
// Valid/ready channel interfaces for input items and pixel items.
// ---------------------------------------------------------------------------
interface swla_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic periodic_turn_bit;
  logic wall_turn_bit;

  modport source (output valid, output mode, output periodic_turn_bit,
                  output wall_turn_bit, input ready);
  modport sink (input valid, input mode, input periodic_turn_bit,
                input wall_turn_bit, output ready);
endinterface

interface swla_out_if import swla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] pixel_col;
  logic [ROW_W-1:0] pixel_row;
  logic [HUE_W-1:0] pixel_hue;
  logic [CLR_W-1:0] pixel_sat;
  logic [CLR_W-1:0] pixel_value;
  logic             frame_last;

  modport source (output valid, output pixel_col, output pixel_row, output pixel_hue,
                  output pixel_sat, output pixel_value, output frame_last,
                  input ready);
  modport sink (input valid, input pixel_col, input pixel_row, input pixel_hue,
                input pixel_sat, input pixel_value, input frame_last,
                output ready);
endinterface

// ===== rtl/core/swla_cfg_regs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Snake walk animator configuration registers
// APB-style register file holding timing and colour settings.
// ---------------------------------------------------------------------------
module swla_cfg_regs import swla_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t      cfg_r, cfg_nxt;
  cfg_addr_t addr;
  logic      wr_en;

  assign pready = 1'b1;
  assign addr   = cfg_addr_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (addr)
        REG_MOVE_INTERVAL:     cfg_nxt.move_interval     = pwdata[CNT_W-1:0];
        REG_MOVES_BEFORE_TURN: cfg_nxt.moves_before_turn = pwdata[CNT_W-1:0];
        REG_HUE_STEP:          cfg_nxt.hue_step          = pwdata[HUE_W-1:0];
        REG_VALUE_STEP:        cfg_nxt.value_step        = pwdata[CLR_W-1:0];
        REG_MAX_VALUE:         cfg_nxt.max_value         = pwdata[CLR_W-1:0];
        REG_START_HUE:         cfg_nxt.start_hue         = pwdata[HUE_W-1:0];
        REG_START_SAT:         cfg_nxt.start_sat         = pwdata[CLR_W-1:0];
        REG_START_VALUE:       cfg_nxt.start_value       = pwdata[CLR_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (addr)
      REG_MOVE_INTERVAL:     prdata = PDATA_W'(cfg_r.move_interval);
      REG_MOVES_BEFORE_TURN: prdata = PDATA_W'(cfg_r.moves_before_turn);
      REG_HUE_STEP:          prdata = PDATA_W'(cfg_r.hue_step);
      REG_VALUE_STEP:        prdata = PDATA_W'(cfg_r.value_step);
      REG_MAX_VALUE:         prdata = PDATA_W'(cfg_r.max_value);
      REG_START_HUE:         prdata = PDATA_W'(cfg_r.start_hue);
      REG_START_SAT:         prdata = PDATA_W'(cfg_r.start_sat);
      REG_START_VALUE:       prdata = PDATA_W'(cfg_r.start_value);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.move_interval     <= CNT_W'(100);
      cfg_r.moves_before_turn <= CNT_W'(2);
      cfg_r.hue_step          <= HUE_W'(328);
      cfg_r.value_step        <= '0;
      cfg_r.max_value         <= CLR_W'(32768);
      cfg_r.start_hue         <= HUE_W'(328);
      cfg_r.start_sat         <= CLR_W'(32768);
      cfg_r.start_value       <= CLR_W'(2294);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/core/swla_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Snake walk animator controller
// Sequences item intake, frame emission, turning and the head step.
// ---------------------------------------------------------------------------
module swla_ctrl import swla_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  dp_sts_t     sts,
  output dp_cmd_t     cmd,
  output ctrl_state_t state
);

  ctrl_state_t state_r, state_nxt;

  assign state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.move_due) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // One pixel per cycle whenever the output register can take it.
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.last_seg) state_nxt = S_TURN;
        end
      end
      S_TURN: begin
        cmd.turn  = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        // At a wall the heading is replaced and the step is retried.
        cmd.step = 1'b1;
        if (!sts.wall) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/swla_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Snake walk animator datapath
// Segment positions, heading, counters, shared colour and the pixel register.
// ---------------------------------------------------------------------------
module swla_datapath import swla_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    in_mode,
  input  logic    in_periodic_turn_bit,
  input  logic    in_wall_turn_bit,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output logic    out_valid,
  input  logic    out_ready,
  output pixel_t  out_pix
);

  logic [COL_W-1:0] seg_col_r [SNAKE_LEN];
  logic [ROW_W-1:0] seg_row_r [SNAKE_LEN];
  heading_t         heading_r;
  logic [CNT_W-1:0] moves_r;
  logic [CNT_W-1:0] ticks_r;
  logic [HUE_W-1:0] hue_r;
  logic [CLR_W-1:0] sat_r;
  logic [CLR_W-1:0] value_r;
  logic [IDX_W-1:0] idx_r;
  logic             pbit_r;
  logic             wbit_r;
  logic             out_valid_r;
  pixel_t           out_pix_r;

  logic [CNT_W-1:0] ticks_inc;
  logic [CNT_W-1:0] moves_inc;
  logic             wall;
  logic [CLR_W:0]   value_sum;

  assign ticks_inc = (ticks_r == CNT_MAX) ? ticks_r : ticks_r + CNT_W'(1);
  assign moves_inc = moves_r + CNT_W'(1);
  assign value_sum = {1'b0, value_r} + {1'b0, cfg.value_step};

  always_comb begin
    case (heading_r)
      HEAD_UP:    wall = (seg_row_r[0] == '0);
      HEAD_RIGHT: wall = (seg_col_r[0] >= COL_LAST);
      HEAD_DOWN:  wall = (seg_row_r[0] >= ROW_LAST);
      default:    wall = (seg_col_r[0] == '0);
    endcase
  end

  assign sts.move_due  = !in_mode && (ticks_inc >= cfg.move_interval);
  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.last_seg  = (idx_r == IDX_LAST);
  assign sts.wall      = wall;

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

  // Architectural snake state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SNAKE_LEN; i++) begin
        seg_col_r[i] <= '0;
        seg_row_r[i] <= '0;
      end
      heading_r <= HEAD_DOWN;
      moves_r   <= '0;
      ticks_r   <= '0;
      hue_r     <= '0;
      sat_r     <= '0;
      value_r   <= '0;
    end else begin
      if (cmd.accept) begin
        if (in_mode) begin
          for (int i = 0; i < SNAKE_LEN; i++) begin
            seg_col_r[i] <= '0;
            seg_row_r[i] <= '0;
          end
          hue_r   <= cfg.start_hue;
          sat_r   <= cfg.start_sat;
          value_r <= cfg.start_value;
          ticks_r <= '0;
        end else if (sts.move_due) begin
          ticks_r <= '0;
        end else begin
          ticks_r <= ticks_inc;
        end
      end
      if (cmd.turn) begin
        // The head keeps its place here, so the turn sees the old head.
        if (moves_inc > cfg.moves_before_turn) begin
          heading_r <= pick_heading(heading_r, seg_col_r[0], seg_row_r[0], pbit_r);
          moves_r   <= '0;
        end else begin
          moves_r <= moves_inc;
        end
        for (int i = 1; i < SNAKE_LEN; i++) begin
          seg_col_r[i] <= seg_col_r[i-1];
          seg_row_r[i] <= seg_row_r[i-1];
        end
      end
      if (cmd.step) begin
        if (wall) begin
          heading_r <= pick_heading(heading_r, seg_col_r[0], seg_row_r[0], wbit_r);
          moves_r   <= '0;
        end else begin
          case (heading_r)
            HEAD_UP:    seg_row_r[0] <= seg_row_r[0] - ROW_W'(1);
            HEAD_RIGHT: seg_col_r[0] <= seg_col_r[0] + COL_W'(1);
            HEAD_DOWN:  seg_row_r[0] <= seg_row_r[0] + ROW_W'(1);
            default:    seg_col_r[0] <= seg_col_r[0] - COL_W'(1);
          endcase
          hue_r   <= hue_r + cfg.hue_step;
          value_r <= (value_sum > {1'b0, cfg.max_value}) ? '0 : value_sum[CLR_W-1:0];
        end
      end
    end
  end

  // Frame index and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx_r <= '0;
      end else if (cmd.emit) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pbit_r <= in_periodic_turn_bit;
      wbit_r <= in_wall_turn_bit;
    end
    if (cmd.emit) begin
      out_pix_r.pixel_col   <= seg_col_r[idx_r];
      out_pix_r.pixel_row   <= seg_row_r[idx_r];
      out_pix_r.pixel_hue   <= hue_r;
      out_pix_r.pixel_sat   <= sat_r;
      out_pix_r.pixel_value <= value_r;
      out_pix_r.frame_last  <= (idx_r == IDX_LAST);
    end
  end

endmodule

// ===== rtl/core/snake_walk_led_animator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Snake walk LED animator
// Moves a snake over a 16 x 16 grid and emits one pixel item per segment.
//
// Input items arrive on in_if: mode 0 is a millisecond tick, mode 1 restarts
// the snake at (0,0) with the start colour. A tick that completes the move
// interval yields a frame of five pixel items on out_if, head first, with
// frame_last set on the tail segment; other items yield nothing.
// After an item that causes no move the intake stays open. A move passes
// through intake, one emission per segment through the output register,
// a turn state and a head step, retried after a wall replaced the heading;
// the next item waits for the step to finish. The output register holds a
// pixel until out_if.ready takes it; while the receiver stalls, emission
// pauses and the snake state does not advance. Synchronous reset (rst_n
// low) loads the register defaults, places every segment at (0,0) heading
// down with zero colour, clears the counters. Registers are to be written
// over the APB-style port only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module snake_walk_led_animator import swla_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  swla_in_if.sink            in_if,
  swla_out_if.source         out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t        cfg;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  ctrl_state_t state;
  pixel_t      pix;
  logic        in_ready;
  logic        out_valid;

  swla_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  swla_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .in_mode              (in_if.mode),
    .in_periodic_turn_bit (in_if.periodic_turn_bit),
    .in_wall_turn_bit     (in_if.wall_turn_bit),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_ready            (out_if.ready),
    .out_pix              (pix)
  );

  assign in_if.ready        = in_ready;
  assign out_if.valid       = out_valid;
  assign out_if.pixel_col   = pix.pixel_col;
  assign out_if.pixel_row   = pix.pixel_row;
  assign out_if.pixel_hue   = pix.pixel_hue;
  assign out_if.pixel_sat   = pix.pixel_sat;
  assign out_if.pixel_value = pix.pixel_value;
  assign out_if.frame_last  = pix.frame_last;

  // A pixel is only loaded when the output register is free or draining.
  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_if.ready))
    else $error("pixel loaded over a pending pixel");

  // No new item is taken while a frame is being emitted.
  a_no_intake_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !in_ready)
    else $error("intake open during frame emission");

  // A restart never starts a frame.
  a_restart_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_ready && in_if.mode) |=> (state == S_IDLE))
    else $error("restart item started a frame");

  // A successful head step returns the block to intake.
  a_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !sts.wall) |=> in_ready)
    else $error("intake not reopened after head step");

endmodule
